// ===== hdl/dsm_pkg.sv =====
// Shared types, codes and helpers of the domain suffix matcher.
// No dependencies; every other file of the block but dsm_ram imports this package.
package dsm_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int ENTRY_LEN_DEF = 64;
    localparam int QUERY_LEN_DEF = 256;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_byte;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic listed;
        logic too_long;
    } t_out_word;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_LOAD,
        K_QUERY,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_byte;
        logic       last;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN_RD,
        S_LEN_CHK,
        S_DOT_RD,
        S_DOT_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_DONE
    } t_state;

    // Fold 'A'..'Z' to lower case; every other byte stands as it is.
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== hdl/dsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/dsm_front.sv =====
// Front end: accepts input words, classifies the opcode, queues commands.
// Depends on dsm_pkg.
module dsm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  dsm_pkg::t_in_word i_in_word,
    output logic             o_cmd_valid,
    output dsm_pkg::t_cmd    o_cmd,
    input  logic             i_cmd_pop
);
    import dsm_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    always_comb begin
        w_cmd.char_byte = i_in_word.char_byte;
        w_cmd.last      = i_in_word.last;
        case (i_in_word.opcode)
            OP_CLEAR: w_cmd.kind = K_CLEAR;
            OP_LOAD:  w_cmd.kind = K_LOAD;
            OP_QUERY: w_cmd.kind = K_QUERY;
            default:  w_cmd.kind = K_NOP;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = push && !full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== hdl/dsm_back.sv =====
// Back end: table loading, query buffering and the entry walk.
// Depends on dsm_pkg and dsm_ram.
module dsm_back #(
    parameter int ENTRIES   = dsm_pkg::ENTRIES_DEF,
    parameter int ENTRY_LEN = dsm_pkg::ENTRY_LEN_DEF,
    parameter int QUERY_LEN = dsm_pkg::QUERY_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  dsm_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    output logic              o_res_valid,
    output dsm_pkg::t_out_word o_res,
    input  logic              i_res_ready
);
    import dsm_pkg::*;

    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int EIW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW  = $clog2(ENTRY_LEN);
    localparam int QW  = $clog2(QUERY_LEN + 1);
    localparam int QAW = $clog2(QUERY_LEN);
    localparam int EAW = (ENTRIES * ENTRY_LEN > 1) ? $clog2(ENTRIES * ENTRY_LEN) : 1;
    localparam int BW  = $clog2(ENTRIES * ENTRY_LEN + 1);
    localparam int MW  = (QW > LW) ? QW : LW;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [LW-1:0] r_llen, n_llen;
    logic [BW-1:0] r_lbase, n_lbase;
    logic [QW-1:0] r_qlen, n_qlen;
    logic          r_qover, n_qover;
    logic [CW-1:0] r_e, n_e;
    logic [BW-1:0] r_ebase, n_ebase;
    logic [LW-1:0] r_elen, n_elen;
    logic [QW-1:0] r_start, n_start;
    logic [LW-1:0] r_i, n_i;
    logic          r_listed, n_listed;
    logic          r_toolong, n_toolong;

    logic           ec_we, el_we, q_we;
    logic [EAW-1:0] ec_waddr, ec_raddr;
    logic [EIW-1:0] el_waddr, el_raddr;
    logic [QAW-1:0] q_waddr, q_raddr;
    logic [LW-1:0]  el_wdata, el_rdata;
    logic [7:0]     ec_rdata, q_rdata;
    logic [LW-1:0]  llen_inc;
    logic [QW-1:0]  q_pos;

    dsm_ram #(.WIDTH(8), .DEPTH(ENTRIES * ENTRY_LEN)) u_entry_chars (
        .i_clk(i_clk), .i_we(ec_we), .i_waddr(ec_waddr), .i_wdata(i_cmd.char_byte),
        .i_raddr(ec_raddr), .o_rdata(ec_rdata)
    );
    dsm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_entry_lengths (
        .i_clk(i_clk), .i_we(el_we), .i_waddr(el_waddr), .i_wdata(el_wdata),
        .i_raddr(el_raddr), .o_rdata(el_rdata)
    );
    dsm_ram #(.WIDTH(8), .DEPTH(QUERY_LEN)) u_query_chars (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(i_cmd.char_byte),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_llen  <= '0;
            r_lbase <= '0;
            r_qlen  <= '0;
            r_qover <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_llen  <= n_llen;
            r_lbase <= n_lbase;
            r_qlen  <= n_qlen;
            r_qover <= n_qover;
        end
        r_e       <= n_e;
        r_ebase   <= n_ebase;
        r_elen    <= n_elen;
        r_start   <= n_start;
        r_i       <= n_i;
        r_listed  <= n_listed;
        r_toolong <= n_toolong;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_llen    = r_llen;
        n_lbase   = r_lbase;
        n_qlen    = r_qlen;
        n_qover   = r_qover;
        n_e       = r_e;
        n_ebase   = r_ebase;
        n_elen    = r_elen;
        n_start   = r_start;
        n_i       = r_i;
        n_listed  = r_listed;
        n_toolong = r_toolong;
        o_cmd_pop = 1'b0;
        ec_we     = 1'b0;
        el_we     = 1'b0;
        q_we      = 1'b0;
        llen_inc  = r_llen + LW'(1);
        ec_waddr  = r_lbase[EAW-1:0] + EAW'(r_llen);
        el_waddr  = r_count[EIW-1:0];
        el_wdata  = r_llen;
        q_waddr   = r_qlen[QAW-1:0];
        q_pos     = r_start + QW'(r_i);
        el_raddr  = r_e[EIW-1:0];
        ec_raddr  = r_ebase[EAW-1:0] + EAW'(r_i);
        q_raddr   = q_pos[QAW-1:0];

        case (r_state)
            S_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        K_CLEAR: begin
                            n_count = '0;
                            n_llen  = '0;
                            n_lbase = '0;
                        end
                        K_LOAD: begin
                            if (r_count != CW'(ENTRIES)) begin
                                if (r_llen != LW'(ENTRY_LEN - 1)) begin
                                    ec_we    = 1'b1;
                                    el_wdata = llen_inc;
                                    n_llen   = llen_inc;
                                end
                                if (i_cmd.last) begin
                                    el_we   = 1'b1;
                                    n_count = r_count + CW'(1);
                                    n_lbase = r_lbase + BW'(ENTRY_LEN);
                                    n_llen  = '0;
                                end
                            end
                        end
                        K_QUERY: begin
                            if (r_qlen != QW'(QUERY_LEN)) begin
                                q_we   = 1'b1;
                                n_qlen = r_qlen + QW'(1);
                            end else begin
                                n_qover = 1'b1;
                            end
                            if (i_cmd.last) begin
                                n_listed  = 1'b0;
                                n_toolong = n_qover;
                                n_e       = '0;
                                n_ebase   = '0;
                                if (n_qover || r_count == '0) begin
                                    n_state = S_DONE;
                                end else begin
                                    n_state = S_LEN_RD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LEN_RD: n_state = S_LEN_CHK;
            S_LEN_CHK: begin
                n_elen  = el_rdata;
                n_i     = '0;
                n_start = r_qlen - QW'(el_rdata);
                if (MW'(el_rdata) > MW'(r_qlen)) begin
                    n_state = S_DONE;
                    if (r_e + CW'(1) != r_count) begin
                        n_e     = r_e + CW'(1);
                        n_ebase = r_ebase + BW'(ENTRY_LEN);
                        n_state = S_LEN_RD;
                    end
                end else if (n_start != '0) begin
                    n_state = S_DOT_RD;
                end else begin
                    n_state = S_CMP_RD;
                end
            end
            S_DOT_RD: begin
                q_pos   = r_start - QW'(1);
                q_raddr = q_pos[QAW-1:0];
                n_state = S_DOT_CHK;
            end
            S_DOT_CHK: begin
                if (q_rdata == DOT_CHAR) begin
                    n_state = S_CMP_RD;
                end else begin
                    n_state = S_DONE;
                    if (r_e + CW'(1) != r_count) begin
                        n_e     = r_e + CW'(1);
                        n_ebase = r_ebase + BW'(ENTRY_LEN);
                        n_state = S_LEN_RD;
                    end
                end
            end
            S_CMP_RD: begin
                if (r_i == r_elen) begin
                    n_listed = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_CMP_CHK;
                end
            end
            S_CMP_CHK: begin
                if (fold(q_rdata) == fold(ec_rdata)) begin
                    n_i     = r_i + LW'(1);
                    n_state = S_CMP_RD;
                end else begin
                    n_state = S_DONE;
                    if (r_e + CW'(1) != r_count) begin
                        n_e     = r_e + CW'(1);
                        n_ebase = r_ebase + BW'(ENTRY_LEN);
                        n_state = S_LEN_RD;
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_qlen  = '0;
                    n_qover = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res_valid    = (r_state == S_DONE);
    assign o_res.listed   = r_listed;
    assign o_res.too_long = r_toolong;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES)) else $error("entry count beyond table");
    a_walk_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN_RD) |-> (r_e < r_count)) else $error("walk past last entry");
    a_cmp_in_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP_CHK) |-> (r_i < r_elen)) else $error("compare past entry end");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE)) else $error("command taken during walk");
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready) |=> (r_qlen == '0 && !r_qover))
        else $error("query buffer not emptied");
`endif
endmodule

// ===== hdl/domain_suffix_matcher.sv =====
// Top level of the domain suffix matcher: front queue, back end, result register.
// Depends on dsm_pkg, dsm_front, dsm_back (and dsm_ram below it).
//
//  channel  | handshake        | word                              | direction
//  ---------+------------------+-----------------------------------+----------
//  input    | push / full      | i_in_word (opcode,char_byte,last) | in
//  result   | empty / pop      | o_out_word (listed,too_long)      | out
//
// Clear, load and non-final query words retire at one per cycle while the back end
// is idle. A final query word walks the table: per entry a length read and check,
// a dot read and check if a label precedes, a read and check per compared character.
// The walk is bound by the single read port of the entry and query memories.
// Reset (synchronous, active low) empties the table, both queues and the query.
// A full result register stalls the back end; a busy back end fills the input queue.
module domain_suffix_matcher #(
    parameter int ENTRIES   = dsm_pkg::ENTRIES_DEF,
    parameter int ENTRY_LEN = dsm_pkg::ENTRY_LEN_DEF,
    parameter int QUERY_LEN = dsm_pkg::QUERY_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  dsm_pkg::t_in_word  i_in_word,
    output logic               empty,
    input  logic               pop,
    output dsm_pkg::t_out_word o_out_word
);
    import dsm_pkg::*;

    logic      cmd_valid, cmd_pop;
    t_cmd      cmd;
    logic      res_valid, res_ready;
    t_out_word res;
    logic      r_ovalid;
    t_out_word r_oword;

    dsm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_in_word(i_in_word), .o_cmd_valid(cmd_valid), .o_cmd(cmd),
        .i_cmd_pop(cmd_pop)
    );

    dsm_back #(.ENTRIES(ENTRIES), .ENTRY_LEN(ENTRY_LEN), .QUERY_LEN(QUERY_LEN)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_pop(cmd_pop), .o_res_valid(res_valid), .o_res(res),
        .i_res_ready(res_ready)
    );

    // Take a new result whenever the register is free or being drained.
    assign res_ready = !r_ovalid || pop;

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_oword <= res;
        end
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ovalid <= 1'b1;
        end else if (pop) begin
            r_ovalid <= 1'b0;
        end
    end

    assign empty      = !r_ovalid;
    assign o_out_word = r_oword;
endmodule

// ===== tb/sv/tb_domain_suffix_matcher.sv =====
// Self-checking testbench of domain_suffix_matcher: directed table, then random sequences.
// Depends on dsm_pkg and the matcher RTL; results are checked against a local predictor.
`timescale 1ns / 100ps

module tb_domain_suffix_matcher;
    import dsm_pkg::*;

    localparam int         N_ENT      = ENTRIES_DEF;
    localparam int         ENT_CHARS  = ENTRY_LEN_DEF;
    localparam int         QRY_CHARS  = QUERY_LEN_DEF;
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         NUM_ITEMS  = 1000;
    localparam int         CYCLE_CAP  = 2_000_000;
    localparam int         DRAIN_WAIT = 200;
    localparam int         HOLD_LEN   = 3000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    t_in_word  i_in_word = '0;
    t_out_word o_out_word;

    domain_suffix_matcher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    always #10 i_clk = ~i_clk;

    // Predicted copy of the domain table and of the query being streamed.
    logic [7:0] tab_chr [N_ENT][ENT_CHARS];
    int         tab_len [N_ENT];
    int         tab_cnt  = 0;
    int         load_pos = 0;
    logic [7:0] qry_chr [QRY_CHARS];
    int         qry_len  = 0;
    bit         qry_over = 1'b0;

    t_out_word  verdicts_due[$];   // expected result words, oldest first
    int         errors       = 0;
    int         cycles       = 0;
    int         send_idle    = 0;
    int         recv_idle    = 0;
    bit         hold_req     = 1'b0;
    int         hold_cnt     = 0;
    bit         pinned_valid = 1'b0; // directed row with a hand-written result
    t_out_word  pinned_res;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
    endfunction

    // Exact match, or suffix match preceded by a dot.
    function automatic bit entry_hits(input int e);
        int start;
        if (tab_len[e] > qry_len) return 1'b0;
        start = qry_len - tab_len[e];
        if (start > 0 && qry_chr[start-1] != DOT_CHAR) return 1'b0;
        for (int i = 0; i < tab_len[e]; i++) begin
            if (to_lower(qry_chr[start+i]) != to_lower(tab_chr[e][i])) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the predicted state by one accepted word; queue a verdict on a query end.
    task automatic predict_word(input t_in_word w);
        t_out_word v;
        case (w.opcode)
            OP_CLEAR: begin
                tab_cnt  = 0;
                load_pos = 0;
            end
            OP_LOAD: begin
                if (tab_cnt < N_ENT) begin
                    if (load_pos < ENT_CHARS - 1) begin
                        tab_chr[tab_cnt][load_pos] = w.char_byte;
                        load_pos++;
                    end
                    if (w.last) begin
                        tab_len[tab_cnt] = load_pos;
                        tab_cnt++;
                        load_pos = 0;
                    end
                end
            end
            OP_QUERY: begin
                if (qry_len < QRY_CHARS) begin
                    qry_chr[qry_len] = w.char_byte;
                    qry_len++;
                end else begin
                    qry_over = 1'b1;
                end
                if (w.last) begin
                    v.too_long = qry_over;
                    v.listed   = 1'b0;
                    if (!qry_over) begin
                        for (int e = 0; e < tab_cnt; e++) begin
                            if (entry_hits(e)) v.listed = 1'b1;
                        end
                    end
                    // A hand-written verdict from the directed table takes the place
                    // of the computed one.
                    if (pinned_valid) begin
                        v = pinned_res;
                        pinned_valid = 1'b0;
                    end
                    verdicts_due.push_back(v);
                    qry_len  = 0;
                    qry_over = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    // Sample both handshakes at the rising edge: predict accepted words, check results.
    always @(posedge i_clk) begin
        t_out_word want;
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end else if (i_rst_n) begin
            if (push && !full) predict_word(i_in_word);
            if (pop && !empty) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: result word expected none actual %b",
                             $realtime, o_out_word);
                    errors++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_out_word.listed !== want.listed) begin
                        $display("%0t: listed expected %b actual %b",
                                 $realtime, want.listed, o_out_word.listed);
                        errors++;
                    end
                    if (o_out_word.too_long !== want.too_long) begin
                        $display("%0t: too_long expected %b actual %b",
                                 $realtime, want.too_long, o_out_word.too_long);
                        errors++;
                    end
                end
            end
        end
    end

    // Result side: random pop, or hold off entirely for a long stretch on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_cnt = HOLD_LEN;
            hold_req = 1'b0;
        end
        if (!i_rst_n || hold_cnt > 0) begin
            if (hold_cnt > 0) hold_cnt--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Offer one word until it is taken; idle at random between offers.
    task automatic send_word(input logic [1:0] op, input logic [7:0] c, input bit lst);
        bit taken;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            if ($urandom_range(99) < send_idle) begin
                push <= 1'b0;
            end else begin
                push      <= 1'b1;
                i_in_word <= '{opcode: op, char_byte: c, last: lst};
                @(posedge i_clk);
                taken = !full;
            end
        end
    endtask

    // Stream a whole entry or query; last rides on the final character.
    task automatic send_text(input logic [1:0] op, input logic [7:0] txt[$]);
        for (int i = 0; i < txt.size(); i++) send_word(op, txt[i], i == txt.size() - 1);
    endtask

    // Small alphabet so that random text often collides with table entries.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 10) return DOT_CHAR;
        if (r < 15) return 8'($urandom_range(255));
        return 8'("a" + $urandom_range(2)) - (($urandom_range(1) == 1) ? 8'h20 : 8'h00);
    endfunction

    typedef struct {
        t_in_word  w;
        bit        pinned;
        t_out_word res;
    } t_row;

    t_row         script[$];
    logic [7:0]   txt[$];
    int           items_sent;
    int           r;
    int           e;
    int           len;

    initial begin
        // Directed words: empty-table query, mixed case, NUL entry, missing dot,
        // unused opcode, all-ones byte, query after a clear.
        script = '{
            '{'{OP_QUERY, "a", 1'b1}, 1'b1, '{1'b0, 1'b0}},
            '{'{OP_CLEAR, 8'hFF, 1'b1}, 1'b0, '0},
            '{'{OP_LOAD, "E", 1'b0}, 1'b0, '0},
            '{'{OP_LOAD, "x", 1'b0}, 1'b0, '0},
            '{'{OP_LOAD, ".", 1'b0}, 1'b0, '0},
            '{'{OP_LOAD, "z", 1'b1}, 1'b0, '0},
            '{'{OP_LOAD, 8'h00, 1'b1}, 1'b0, '0},
            '{'{OP_QUERY, "e", 1'b0}, 1'b0, '0},
            '{'{OP_QUERY, "X", 1'b0}, 1'b0, '0},
            '{'{OP_QUERY, ".", 1'b0}, 1'b0, '0},
            '{'{OP_QUERY, "Z", 1'b1}, 1'b0, '0},
            '{'{OP_QUERY, "q", 1'b0}, 1'b0, '0},
            '{'{OP_QUERY, ".", 1'b0}, 1'b0, '0},
            '{'{OP_QUERY, 8'h00, 1'b1}, 1'b0, '0},
            '{'{OP_QUERY, "q", 1'b0}, 1'b0, '0},
            '{'{OP_QUERY, 8'h00, 1'b1}, 1'b0, '0},
            '{'{OP_UNUSED, 8'hFF, 1'b1}, 1'b0, '0},
            '{'{OP_QUERY, 8'hFF, 1'b1}, 1'b0, '0},
            '{'{OP_CLEAR, 8'h00, 1'b0}, 1'b0, '0},
            '{'{OP_QUERY, "e", 1'b0}, 1'b0, '0},
            '{'{OP_QUERY, "x", 1'b0}, 1'b0, '0},
            '{'{OP_QUERY, ".", 1'b0}, 1'b0, '0},
            '{'{OP_QUERY, "z", 1'b1}, 1'b1, '{1'b0, 1'b0}}
        };

        send_idle = 18;
        recv_idle = 62;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].pinned) begin
                pinned_res   = script[i].res;
                pinned_valid = 1'b1;
            end
            send_word(script[i].w.opcode, script[i].w.char_byte, script[i].w.last);
        end

        // Overlong query once: overflow sets too_long and drops listed.
        txt = {};
        repeat (QRY_CHARS + 3) txt.push_back(pick_char());
        send_text(OP_QUERY, txt);

        // The directed words count towards the total.
        items_sent = script.size() + txt.size();
        while (items_sent < NUM_ITEMS) begin
            if (items_sent >= 2 * NUM_ITEMS / 3 && send_idle != 0) begin
                // Last phase: no idling, and the result side stalls long enough
                // for the input queue to back up behind a burst of queries.
                send_idle = 0;
                recv_idle = 0;
                hold_req  = 1'b1;
                repeat (60) send_word(OP_QUERY, pick_char(), 1'b1);
                items_sent += 60;
            end else if (items_sent >= NUM_ITEMS / 3 && send_idle == 18) begin
                send_idle = 62;
                recv_idle = 18;
            end
            r   = $urandom_range(99);
            txt = {};
            if (r < 6) begin
                send_word(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
                items_sent++;
            end else if (r < 36) begin
                // One entry, occasionally long enough to be truncated.
                len = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
                repeat (len) txt.push_back(pick_char());
                send_text(OP_LOAD, txt);
                items_sent += len;
            end else if (r < 38) begin
                // Fill the table past its end with short entries.
                send_word(OP_CLEAR, 8'h00, 1'b1);
                repeat (N_ENT + 2) begin
                    txt = {};
                    repeat ($urandom_range(1, 2)) txt.push_back(pick_char());
                    send_text(OP_LOAD, txt);
                    items_sent += txt.size();
                end
            end else if (r < 92) begin
                // Query: mostly a listed entry with an optional label and a random case,
                // sometimes with a corrupted separator, sometimes random text.
                if (tab_cnt > 0 && $urandom_range(3) != 0) begin
                    e = $urandom_range(tab_cnt - 1);
                    if ($urandom_range(1) == 1) begin
                        repeat ($urandom_range(1, 4)) txt.push_back(pick_char());
                        txt.push_back(($urandom_range(4) == 0) ? pick_char() : DOT_CHAR);
                    end
                    for (int i = 0; i < tab_len[e]; i++) begin
                        txt.push_back(($urandom_range(1) == 1 && tab_chr[e][i] >= "a"
                                       && tab_chr[e][i] <= "z") ?
                                      tab_chr[e][i] - 8'h20 : tab_chr[e][i]);
                    end
                    if ($urandom_range(7) == 0) txt.push_back(pick_char());
                end else begin
                    repeat ($urandom_range(1, 8)) txt.push_back(pick_char());
                end
                send_text(OP_QUERY, txt);
                items_sent += txt.size();
            end else begin
                // Ignored opcode: not counted as an item.
                send_word(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end

        @(negedge i_clk);
        push <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dsm_pkg.sv
hdl/dsm_ram.sv
hdl/dsm_front.sv
hdl/dsm_back.sv
hdl/domain_suffix_matcher.sv
tb/sv/tb_domain_suffix_matcher.sv
